FILE: hw/rtl/lpht_pkg.sv
// ============================================================================
// lpht_pkg
// Shared types, widths and codes for the linear-probing hash table core.
// ============================================================================
`default_nettype none

package lpht_pkg;

  // Field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned ST_W       = 2;

  // Stream data widths, rounded up to whole bytes
  localparam int unsigned IN_DATA_W  = ((KEY_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned IN_USER_W  = OP_W;
  localparam int unsigned OUT_DATA_W = ((VAL_W + SLOT_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = STATUS_W;

  // Default table depth
  localparam int unsigned TABLE_SIZE_DEF = 16;

  // Remainder unit: key padded to HKEY_W bits, HASH_DIGIT_W bits per step
  localparam int unsigned HKEY_W       = 32;
  localparam int unsigned HASH_DIGIT_W = 4;
  localparam int unsigned HASH_STEPS   = HKEY_W / HASH_DIGIT_W;
  localparam int unsigned HCNT_W       = $clog2(HASH_STEPS);

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Slot states
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd0;
  localparam logic [ST_W-1:0] ST_USED    = 2'd1;
  localparam logic [ST_W-1:0] ST_DELETED = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] RES_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] RES_FULL      = 2'd2;

  // One table entry as held in the slot RAM
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
    logic [ST_W-1:0]  st;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;
    logic load;
    logic hash;
    logic probe;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic probe_stop;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lpht_ram.sv
// ============================================================================
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_ctrl.sv
// ============================================================================
// lpht_ctrl
// Sequencer: clearing pass, request intake, hashing, probing and result hand-off.
// ============================================================================
`default_nettype none

module lpht_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire lpht_pkg::dp_stat_t stat_i,
  output lpht_pkg::dp_cmd_t       cmd_o
);

  import lpht_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        if (stat_i.hash_last) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd_o.probe = 1'b1;
        if (stat_i.probe_stop) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // wait for the output register to drain
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_dp.sv
// ============================================================================
// lpht_dp
// Datapath: request registers, home-slot remainder unit, probe pointers,
// hit/free decision, slot RAM write-back and the output register.
// ============================================================================
`default_nettype none

module lpht_dp #(
  parameter int unsigned TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire lpht_pkg::dp_cmd_t                  cmd_i,
  output lpht_pkg::dp_stat_t                      stat_o,
  input  wire logic [lpht_pkg::OP_W-1:0]          req_op_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]         req_key_i,
  input  wire logic [lpht_pkg::VAL_W-1:0]         req_val_i,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic      [lpht_pkg::STATUS_W-1:0]      out_status_o,
  output logic      [lpht_pkg::VAL_W-1:0]         out_fval_o,
  output logic      [lpht_pkg::SLOT_W-1:0]        out_slot_o,
  output logic                                    ram_we_o,
  output logic      [$clog2(TABLE_SIZE)-1:0]      ram_waddr_o,
  output logic      [lpht_pkg::ENTRY_W-1:0]       ram_wdata_o,
  output logic      [$clog2(TABLE_SIZE)-1:0]      ram_raddr_o,
  input  wire logic [lpht_pkg::ENTRY_W-1:0]       ram_rdata_i
);

  import lpht_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_SIZE);
  localparam int unsigned SX_W    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam bit          IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W:0]     MODULUS  = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [HCNT_W-1:0]  LAST_HCNT = HCNT_W'(HASH_STEPS - 1);

  // Request registers
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Remainder unit
  logic [HKEY_W-1:0] kshift_q, kshift_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic [IDX_W-1:0]  rem_step;
  logic [IDX_W-1:0]  home;
  logic              hash_last;

  // Probe pointers and clear sweep
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] eval_q, eval_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  // Decision
  entry_t            ent;
  entry_t            wentry;
  logic              stop;
  logic              wr;
  logic              hit;
  logic [STATUS_W-1:0] st_res;
  logic              last_probe;
  logic [SX_W-1:0]   eval_ext;

  // Result and output registers
  logic [STATUS_W-1:0] res_status_q;
  logic [VAL_W-1:0]    res_fval_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [VAL_W-1:0]    out_fval_q;
  logic [SLOT_W-1:0]   out_slot_q;

  // Next slot on the probe path, wrapping at the table end
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nx;
    nx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    return nx;
  endfunction

  // One remainder digit: shift in HASH_DIGIT_W key bits, restoring subtract
  function automatic logic [IDX_W-1:0] rem_digit(input logic [IDX_W-1:0]        rem,
                                                 input logic [HASH_DIGIT_W-1:0] bits);
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] r;
    r = rem;
    for (int i = HASH_DIGIT_W - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= MODULUS) begin
        t = t - MODULUS;
      end
      r = t[IDX_W-1:0];
    end
    return r;
  endfunction

  // Remainder unit
  assign rem_step  = rem_digit(rem_q, kshift_q[HKEY_W-1 -: HASH_DIGIT_W]);
  assign hash_last = IS_POW2 ? 1'b1 : (hcnt_q == LAST_HCNT);
  assign home      = IS_POW2 ? rem_q : rem_step;

  always_comb begin
    kshift_d = kshift_q;
    rem_d    = rem_q;
    hcnt_d   = hcnt_q;
    if (cmd_i.load) begin
      kshift_d = HKEY_W'(req_key_i);
      rem_d    = IS_POW2 ? req_key_i[IDX_W-1:0] : '0;
      hcnt_d   = '0;
    end else if (cmd_i.hash && !IS_POW2) begin
      kshift_d = kshift_q << HASH_DIGIT_W;
      rem_d    = rem_step;
      hcnt_d   = hcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_op_i;
      key_q <= req_key_i;
      val_q <= req_val_i;
    end
    kshift_q <= kshift_d;
    rem_q    <= rem_d;
    hcnt_q   <= hcnt_d;
  end

  // Probe pointers: cur is the address being read, eval the one whose data is back
  always_comb begin
    cur_d  = cur_q;
    eval_d = eval_q;
    cnt_d  = cnt_q;
    if (cmd_i.hash && hash_last) begin
      cur_d  = next_idx(home);
      eval_d = home;
      cnt_d  = '0;
    end else if (cmd_i.probe) begin
      cur_d  = next_idx(cur_q);
      eval_d = cur_q;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    eval_q <= eval_d;
    cnt_q  <= cnt_d;
  end

  // Clearing sweep after reset
  assign clr_d = cmd_i.clr ? next_idx(clr_q) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // Probe decision on the entry just read
  assign ent        = entry_t'(ram_rdata_i);
  assign last_probe = (cnt_q == LAST_IDX);

  always_comb begin
    stop   = 1'b0;
    wr     = 1'b0;
    hit    = 1'b0;
    st_res = RES_NOT_FOUND;
    wentry = ent;
    case (op_q)
      OP_INSERT: begin
        if (ent.st != ST_USED) begin
          stop         = 1'b1;
          wr           = 1'b1;
          st_res       = RES_OK;
          wentry.st    = ST_USED;
          wentry.key   = key_q;
          wentry.value = val_q;
        end else if (last_probe) begin
          stop   = 1'b1;
          st_res = RES_FULL;
        end
      end
      OP_SEARCH, OP_DELETE: begin
        if (ent.st == ST_EMPTY) begin
          stop = 1'b1;
        end else if (ent.st == ST_USED && ent.key == key_q) begin
          stop   = 1'b1;
          hit    = 1'b1;
          st_res = RES_OK;
          if (op_q == OP_DELETE) begin
            wr        = 1'b1;
            wentry.st = ST_DELETED;
          end
        end else if (last_probe) begin
          stop = 1'b1;
        end
      end
      default: begin
        // unused op code: answered as not found
        stop = 1'b1;
      end
    endcase
  end

  // RAM ports
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = eval_q;
    ram_wdata_o = ENTRY_W'(wentry);
    ram_raddr_o = cur_q;
    if (cmd_i.clr) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = clr_q;
      ram_wdata_o = '0;
    end else if (cmd_i.probe && wr) begin
      ram_we_o = 1'b1;
    end
    if (cmd_i.hash && hash_last) begin
      ram_raddr_o = home;
    end
  end

  // Result latch at the end of the probe
  assign eval_ext = SX_W'(eval_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe && stop) begin
      res_status_q <= st_res;
      res_fval_q   <= hit ? ent.value : '0;
      res_slot_q   <= (st_res == RES_OK) ? eval_ext[SLOT_W-1:0] : '0;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_fval_q   <= res_fval_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_fval_o   = out_fval_q;
  assign out_slot_o   = out_slot_q;

  // Status to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = (clr_q == LAST_IDX);
    stat_o.hash_last  = hash_last;
    stat_o.probe_stop = stop;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table_core.sv
// ============================================================================
// linear_probe_hash_table_core
// Open-addressed hash table with linear probing and tombstones.
// ============================================================================
// Usage:
//   Slave stream takes one request: tuser carries the op (insert, search,
//   delete), tdata the key and the value. Master stream returns exactly one
//   result per request: tuser carries the status, tdata the stored value on
//   a hit and the slot index (low four bits).
//   Each request, from acceptance to result valid, passes a hash phase in
//   the four-bit-per-cycle remainder unit (when TABLE_SIZE is a power of
//   two the home slot is the low key bits); then one slot is visited per
//   cycle (1 to TABLE_SIZE slots), set by the single read port of the slot
//   RAM; then the result moves into the output register once it is free.
//   One request is worked on at a time; the next is taken once the result
//   has reached the output register.
//   After reset a clearing pass marks every slot empty;
//   tready stays low during it.
//   A stalled result holds in the output register; a request may still be
//   accepted and worked on, and its result waits until the register drains.
// ============================================================================
`default_nettype none

module linear_probe_hash_table_core #(
  parameter int unsigned TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: key[30:0], value[62:31], zero pad
  input  wire logic [lpht_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: op[1:0]
  input  wire logic [lpht_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: found_value[31:0], slot[35:32], zero pad
  output logic      [lpht_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: status[1:0]
  output logic      [lpht_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [KEY_W-1:0]    req_key;
  logic [VAL_W-1:0]    req_val;
  logic [STATUS_W-1:0] out_status;
  logic [VAL_W-1:0]    out_fval;
  logic [SLOT_W-1:0]   out_slot;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Unpack the request
  assign req_key = s_axis_tdata[KEY_W-1:0];
  assign req_val = s_axis_tdata[KEY_W +: VAL_W];

  // Sequencer
  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath
  lpht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_op_i     (s_axis_tuser[OP_W-1:0]),
    .req_key_i    (req_key),
    .req_val_i    (req_val),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_fval_o   (out_fval),
    .out_slot_o   (out_slot),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  // Slot store: state, key and value of every slot
  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pack the result
  assign m_axis_tdata = OUT_DATA_W'({out_slot, out_fval});
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire
